// ----- rtl/meo_pkg.sv -----
// package for the matrix elementary operations engine
// constants, command codes and fixed-point helpers; no dependencies
package meo_pkg;
  localparam int MAX_DIM = 16;
  localparam int FRAC_BITS = 16;
  localparam int DIM_W = $clog2(MAX_DIM + 1);
  localparam int IDX_W = $clog2(MAX_DIM);
  localparam int ADDR_W = 2 * IDX_W;
  localparam int DEPTH = MAX_DIM * MAX_DIM;

  typedef logic [3:0] func_t;
  localparam func_t FN_WRITE = 4'd0;
  localparam func_t FN_READ = 4'd1;
  localparam func_t FN_SCALE_ROW = 4'd2;
  localparam func_t FN_SWAP_ROW = 4'd3;
  localparam func_t FN_ADD_ROW = 4'd4;
  localparam func_t FN_SCALE_COL = 4'd5;
  localparam func_t FN_SWAP_COL = 4'd6;
  localparam func_t FN_ADD_COL = 4'd7;
  localparam func_t FN_STATUS = 4'd8;
  localparam func_t FN_CLEAR = 4'd9;

  localparam logic [0:0] REG_ROWS = 1'b0;
  localparam logic [0:0] REG_COLS = 1'b1;

  typedef struct packed {
    logic [31:0] read_value;
    logic ok;
    logic all_zero;
    logic upper_tri;
    logic lower_tri;
  } result_t;

  function automatic logic [DIM_W-1:0] clamp_dim(input logic [4:0] v);
    logic [DIM_W-1:0] r;
    if (v == 5'd0) r = DIM_W'(1);
    else if (32'(v) > MAX_DIM) r = DIM_W'(MAX_DIM);
    else r = DIM_W'(v);
    return r;
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'sh7fffffff) r = 32'sh7fffffff;
    else if (v < -64'sh80000000) r = -32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction
endpackage

// ----- rtl/meo_if.sv -----
// valid/ready channel interface carrying one payload beat
// depends on nothing; payload type given by the instantiating level
interface meo_if #(parameter type payload_t = logic) (input logic clk);
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/meo_mul.sv -----
// shared fixed-point multiply unit: registered 32x32 product, then round and saturate
// depends on meo_pkg
module meo_mul (
  input  logic clk,
  input  logic signed [31:0] a,
  input  logic signed [31:0] b,
  output logic signed [31:0] q
);
  import meo_pkg::*;
  logic signed [63:0] prod;
  logic signed [63:0] rnd;
  always_ff @(posedge clk) begin
    prod <= a * b;
  end
  always_comb begin
    rnd = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
    q = sat32(rnd);
  end
endmodule

// ----- rtl/meo_core.sv -----
// sequencer and element store: walks rows/columns with read-modify-write
// depends on meo_pkg and meo_mul
module meo_core (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  meo_pkg::func_t func,
  input  logic [4:0] index_a,
  input  logic [4:0] index_b,
  input  logic signed [31:0] factor,
  input  logic signed [31:0] elem_value,
  input  logic [meo_pkg::DIM_W-1:0] rows,
  input  logic [meo_pkg::DIM_W-1:0] cols,
  output logic busy,
  output logic done,
  output meo_pkg::result_t res
);
  import meo_pkg::*;

  typedef enum logic [6:0] {
    S_IDLE = 7'b0000001, S_RD_A = 7'b0000010, S_RD_B = 7'b0000100,
    S_MUL = 7'b0001000, S_WR_A = 7'b0010000, S_WR_B = 7'b0100000,
    S_DONE = 7'b1000000
  } state_t;

  state_t state;
  logic [31:0] mem [DEPTH];
  logic [31:0] rdata;
  logic [ADDR_W-1:0] raddr;
  logic we;
  logic [ADDR_W-1:0] waddr;
  logic [31:0] wdata;

  func_t fn;
  logic [IDX_W-1:0] ia, ib;
  logic signed [31:0] fac;
  logic [DIM_W-1:0] cnt, lim, cnt_j;
  logic [31:0] val_a, val_b;
  logic clr;
  logic [ADDR_W-1:0] clr_addr;
  logic az, up, lo;
  logic signed [31:0] mq;
  logic signed [31:0] mul_a;
  logic signed [31:0] elem_value_q;
  logic ok_q;
  logic [1:0] stage;
  logic last;

  logic a_row, b_row, a_col, b_col, is_row, valid_cmd;
  always_comb begin
    a_row = index_a != 5'd0 && 32'(index_a) <= 32'(rows);
    b_row = index_b != 5'd0 && 32'(index_b) <= 32'(rows);
    a_col = index_a != 5'd0 && 32'(index_a) <= 32'(cols);
    b_col = index_b != 5'd0 && 32'(index_b) <= 32'(cols);
    case (func)
      FN_WRITE, FN_READ: valid_cmd = a_row && b_col;
      FN_SCALE_ROW: valid_cmd = a_row;
      FN_SWAP_ROW, FN_ADD_ROW: valid_cmd = a_row && b_row;
      FN_SCALE_COL: valid_cmd = a_col;
      FN_SWAP_COL, FN_ADD_COL: valid_cmd = a_col && b_col;
      FN_STATUS, FN_CLEAR: valid_cmd = 1'b1;
      default: valid_cmd = 1'b0;
    endcase
  end
  assign is_row = fn == FN_SCALE_ROW || fn == FN_SWAP_ROW || fn == FN_ADD_ROW;

  // element addresses for current step
  logic [IDX_W-1:0] ci;
  logic [ADDR_W-1:0] addr_a, addr_b, addr_s;
  assign ci = cnt[IDX_W-1:0];
  assign addr_a = is_row ? {ia, ci} : {ci, ia};
  assign addr_b = is_row ? {ib, ci} : {ci, ib};
  assign addr_s = {cnt[IDX_W-1:0], cnt_j[IDX_W-1:0]};

  always_comb begin
    raddr = addr_a;
    if (fn == FN_STATUS) raddr = addr_s;
    else if (fn == FN_READ) raddr = {ia, ib};
    else if (state == S_RD_B) raddr = addr_b;
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  assign mul_a = (fn == FN_ADD_ROW || fn == FN_ADD_COL) ? signed'(val_b) : signed'(val_a);
  meo_mul u_mul (.clk(clk), .a(mul_a), .b(fac), .q(mq));

  always_comb begin
    we = 1'b0;
    waddr = addr_a;
    wdata = val_b;
    if (clr) begin
      we = 1'b1;
      waddr = clr_addr;
      wdata = '0;
    end else if (state == S_WR_A) begin
      we = fn != FN_STATUS;
      case (fn)
        FN_WRITE: begin waddr = {ia, ib}; wdata = elem_value_q; end
        FN_SCALE_ROW, FN_SCALE_COL: wdata = mq;
        FN_ADD_ROW, FN_ADD_COL:
          wdata = sat32(64'(signed'(val_a)) + 64'(mq));
        default: wdata = val_b;
      endcase
    end else if (state == S_WR_B) begin
      we = 1'b1;
      waddr = addr_b;
      wdata = val_a;
    end
  end

  assign last = cnt == lim - DIM_W'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      clr <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= state == S_DONE;
      case (state)
        S_IDLE: if (start) begin
          fn <= func;
          ia <= IDX_W'(index_a - 5'd1);
          ib <= IDX_W'(index_b - 5'd1);
          fac <= factor;
          elem_value_q <= elem_value;
          ok_q <= valid_cmd;
          cnt <= '0;
          cnt_j <= '0;
          clr_addr <= '0;
          stage <= '0;
          az <= 1'b1;
          up <= rows == cols;
          lo <= rows == cols;
          lim <= (func == FN_SCALE_ROW || func == FN_SWAP_ROW || func == FN_ADD_ROW)
                 ? cols : rows;
          res <= '0;
          if (!valid_cmd) state <= S_DONE;
          else if (func == FN_CLEAR) begin clr <= 1'b1; state <= S_MUL; end
          else if (func == FN_WRITE) state <= S_WR_A;
          else state <= S_RD_A;
        end
        S_RD_A: begin
          // wait for the registered read data
          if (stage == 2'd0) stage <= 2'd1;
          else begin
            stage <= 2'd0;
            if (fn == FN_READ) begin
              res.read_value <= rdata;
              state <= S_DONE;
            end else if (fn == FN_STATUS) begin
              if (rdata != '0) begin
                az <= 1'b0;
                if (cnt > cnt_j) up <= 1'b0;
                if (cnt < cnt_j) lo <= 1'b0;
              end
              if (cnt_j == cols - DIM_W'(1)) begin
                cnt_j <= '0;
                if (cnt == rows - DIM_W'(1)) state <= S_DONE;
                else cnt <= cnt + DIM_W'(1);
              end else cnt_j <= cnt_j + DIM_W'(1);
            end else begin
              val_a <= rdata;
              state <= (fn == FN_SCALE_ROW || fn == FN_SCALE_COL) ? S_MUL : S_RD_B;
            end
          end
        end
        S_RD_B: begin
          if (stage == 2'd0) stage <= 2'd1;
          else begin
            stage <= 2'd0;
            val_b <= rdata;
            state <= (fn == FN_SWAP_ROW || fn == FN_SWAP_COL) ? S_WR_A : S_MUL;
          end
        end
        S_MUL: begin
          if (clr) begin
            // one store entry zeroed per cycle
            if (clr_addr == ADDR_W'(DEPTH - 1)) begin
              clr <= 1'b0;
              state <= S_DONE;
            end else clr_addr <= clr_addr + ADDR_W'(1);
          end else begin
            // wait for the product register to fill
            if (stage == 2'd0) stage <= 2'd1;
            else begin stage <= 2'd0; state <= S_WR_A; end
          end
        end
        S_WR_A: begin
          if (fn == FN_WRITE) state <= S_DONE;
          else if (fn == FN_SWAP_ROW || fn == FN_SWAP_COL) state <= S_WR_B;
          else if (last) state <= S_DONE;
          else begin cnt <= cnt + DIM_W'(1); state <= S_RD_A; end
        end
        S_WR_B: begin
          if (last) state <= S_DONE;
          else begin cnt <= cnt + DIM_W'(1); state <= S_RD_A; end
        end
        S_DONE: begin
          res.ok <= ok_q;
          if (ok_q && fn == FN_STATUS) begin
            res.all_zero <= az;
            res.upper_tri <= up;
            res.lower_tri <= lo;
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign busy = state != S_IDLE;
endmodule

// ----- rtl/matrix_elementary_ops_engine.sv -----
// matrix elementary operations engine, top level: channels, APB registers, output register
// depends on meo_pkg, meo_if, meo_core
// flow: one command in flight; the next is accepted only once the result beat has been taken
// reset: sync, active high; registers return to 16; store contents undefined until written
module matrix_elementary_ops_engine (
  input  logic clk,
  input  logic rst,
  meo_if.sink cmd,
  meo_if.source rsp,
  input  logic psel,
  input  logic penable,
  input  logic pwrite,
  input  logic [2:0] paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic pready
);
  import meo_pkg::*;

  logic [DIM_W-1:0] rows_in_use, cols_in_use;
  logic busy, done, pending;
  result_t res;

  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      rows_in_use <= clamp_dim(5'd16);
      cols_in_use <= clamp_dim(5'd16);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00 && !paddr[2]) begin
      if (paddr[2] == REG_ROWS) rows_in_use <= clamp_dim(pwdata[4:0]);
    end else if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
      if (paddr[2] == REG_COLS) cols_in_use <= clamp_dim(pwdata[4:0]);
    end
  end
  assign prdata = paddr[2] == REG_ROWS ? 32'(rows_in_use) : 32'(cols_in_use);

  assign cmd.ready = !busy && !pending && !rsp.valid;

  meo_core u_core (
    .clk(clk), .rst(rst), .start(cmd.valid && cmd.ready),
    .func(cmd.data.func), .index_a(cmd.data.index_a), .index_b(cmd.data.index_b),
    .factor(cmd.data.factor), .elem_value(cmd.data.elem_value),
    .rows(rows_in_use), .cols(cols_in_use),
    .busy(busy), .done(done), .res(res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
      pending <= 1'b0;
    end else begin
      if (cmd.valid && cmd.ready) pending <= 1'b1;
      if (done) begin
        rsp.valid <= 1'b1;
        pending <= 1'b0;
      end else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (done) begin
      rsp.data.read_value <= res.read_value;
      rsp.data.ok <= res.ok;
      rsp.data.all_zero <= res.all_zero;
      rsp.data.upper_tri <= res.upper_tri;
      rsp.data.lower_tri <= res.lower_tri;
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (rst)
    busy |-> !cmd.ready) else $error("command taken while busy");
  a_done_one: assert property (@(posedge clk) disable iff (rst)
    done |=> rsp.valid) else $error("result lost");
  a_tri_square: assert property (@(posedge clk) disable iff (rst)
    (rsp.valid && rows_in_use != cols_in_use && $stable(rows_in_use) && $stable(cols_in_use)
     && $past(done)) |-> !rsp.data.upper_tri && !rsp.data.lower_tri)
    else $error("triangular flag on non-square matrix");
endmodule

// ----- test/tb_top.sv -----
// testbench for matrix_elementary_ops_engine: directed and random command beats
// checked against a behavioral matrix model; depends on meo_pkg, meo_if and the rtl top
`timescale 1ns / 1ps

module tb_top;
  import meo_pkg::*;

  typedef struct packed {
    logic [3:0] func;
    logic [4:0] index_a;
    logic [4:0] index_b;
    logic signed [31:0] factor;
    logic signed [31:0] elem_value;
  } cmd_t;

  localparam int CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [2:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic pready;

  meo_if #(.payload_t(cmd_t)) cmd (.clk(clk));
  meo_if #(.payload_t(result_t)) rsp (.clk(clk));

  matrix_elementary_ops_engine i_dut (
    .clk(clk),
    .rst(rst),
    .cmd(cmd.sink),
    .rsp(rsp.source),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  logic signed [31:0] matrix [DEPTH];
  int unsigned rows_used;
  int unsigned cols_used;
  result_t pending_results[$];
  int unsigned errors;
  int unsigned beats_sent;
  int unsigned beats_checked;
  int unsigned config_writes;
  int unsigned cycles = 0;
  bit fast_sender;
  bit fast_receiver;
  int unsigned hold_off_cycles;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles,
               pending_results.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  // fixed-point product, round half up, saturated
  function automatic logic signed [31:0] fx_product(logic signed [31:0] a,
                                                    logic signed [31:0] b);
    longint p;
    longint q;
    p = longint'(a) * longint'(b) + (longint'(1) << (FRAC_BITS - 1));
    q = p >>> FRAC_BITS;
    if (q > 64'sd2147483647) return 32'sh7fffffff;
    if (q < -64'sd2147483648) return -32'sh80000000;
    return q[31:0];
  endfunction

  function automatic logic signed [31:0] fx_sum(logic signed [31:0] a, logic signed [31:0] b);
    longint s;
    s = longint'(a) + longint'(b);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return -32'sh80000000;
    return s[31:0];
  endfunction

  function automatic int unsigned clamp_size(logic [4:0] v);
    if (v == 0) return 1;
    if (v > MAX_DIM) return MAX_DIM;
    return v;
  endfunction

  function automatic int unsigned slot(int unsigned r, int unsigned c);
    return (r - 1) * MAX_DIM + (c - 1);
  endfunction

  function automatic result_t execute_matrix_cmd(cmd_t c);
    result_t res;
    int unsigned a;
    int unsigned b;
    bit a_row;
    bit b_row;
    bit a_col;
    bit b_col;
    logic signed [31:0] t;
    res = '0;
    a = c.index_a;
    b = c.index_b;
    a_row = a >= 1 && a <= rows_used;
    b_row = b >= 1 && b <= rows_used;
    a_col = a >= 1 && a <= cols_used;
    b_col = b >= 1 && b <= cols_used;
    case (c.func)
      FN_WRITE: if (a_row && b_col) begin
        matrix[slot(a, b)] = c.elem_value;
        res.ok = 1'b1;
      end
      FN_READ: if (a_row && b_col) begin
        res.read_value = matrix[slot(a, b)];
        res.ok = 1'b1;
      end
      FN_SCALE_ROW: if (a_row) begin
        for (int i = 1; i <= cols_used; i++)
          matrix[slot(a, i)] = fx_product(matrix[slot(a, i)], c.factor);
        res.ok = 1'b1;
      end
      FN_SWAP_ROW: if (a_row && b_row) begin
        for (int i = 1; i <= cols_used; i++) begin
          t = matrix[slot(a, i)];
          matrix[slot(a, i)] = matrix[slot(b, i)];
          matrix[slot(b, i)] = t;
        end
        res.ok = 1'b1;
      end
      FN_ADD_ROW: if (a_row && b_row) begin
        for (int i = 1; i <= cols_used; i++)
          matrix[slot(a, i)] = fx_sum(matrix[slot(a, i)],
                                      fx_product(c.factor, matrix[slot(b, i)]));
        res.ok = 1'b1;
      end
      FN_SCALE_COL: if (a_col) begin
        for (int i = 1; i <= rows_used; i++)
          matrix[slot(i, a)] = fx_product(matrix[slot(i, a)], c.factor);
        res.ok = 1'b1;
      end
      FN_SWAP_COL: if (a_col && b_col) begin
        for (int i = 1; i <= rows_used; i++) begin
          t = matrix[slot(i, a)];
          matrix[slot(i, a)] = matrix[slot(i, b)];
          matrix[slot(i, b)] = t;
        end
        res.ok = 1'b1;
      end
      FN_ADD_COL: if (a_col && b_col) begin
        for (int i = 1; i <= rows_used; i++)
          matrix[slot(i, a)] = fx_sum(matrix[slot(i, a)],
                                      fx_product(c.factor, matrix[slot(i, b)]));
        res.ok = 1'b1;
      end
      FN_STATUS: begin
        res.ok = 1'b1;
        res.all_zero = 1'b1;
        res.upper_tri = rows_used == cols_used;
        res.lower_tri = rows_used == cols_used;
        for (int i = 1; i <= rows_used; i++)
          for (int j = 1; j <= cols_used; j++)
            if (matrix[slot(i, j)] != 0) begin
              res.all_zero = 1'b0;
              if (i > j) res.upper_tri = 1'b0;
              if (i < j) res.lower_tri = 1'b0;
            end
      end
      FN_CLEAR: begin
        for (int i = 0; i < DEPTH; i++) matrix[i] = '0;
        res.ok = 1'b1;
      end
      default: ;
    endcase
    return res;
  endfunction

  // sender: valid is left high after a beat, so back-to-back beats need no idle gap
  task automatic send_cmd(cmd_t c);
    int unsigned gap;
    gap = fast_sender ? 0 : $urandom_range(0, 19);
    if (gap > 0) begin
      cmd.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    cmd.data <= c;
    cmd.valid <= 1'b1;
    @(posedge clk);
    while (!cmd.ready) @(posedge clk);
    pending_results.push_back(execute_matrix_cmd(c));
    beats_sent++;
    @(negedge clk);
  endtask

  task automatic stop_sending();
    cmd.valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic send_op(func_t f, int a, int b, int signed fac = 0, int signed val = 0);
    cmd_t c;
    c.func = f;
    c.index_a = 5'(a);
    c.index_b = 5'(b);
    c.factor = fac;
    c.elem_value = val;
    send_cmd(c);
  endtask

  task automatic wait_drained();
    stop_sending();
    while (pending_results.size() != 0) @(negedge clk);
    repeat (20) @(negedge clk);
  endtask

  task automatic reg_write(logic [0:0] idx, logic [31:0] value);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (idx == REG_ROWS) rows_used = clamp_size(value[4:0]);
    else cols_used = clamp_size(value[4:0]);
    config_writes++;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_shape(logic [31:0] r, logic [31:0] c);
    wait_drained();
    reg_write(REG_ROWS, r);
    reg_write(REG_COLS, c);
  endtask

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 5))
      0, 1: return 0;
      2: return $signed($urandom_range(0, 32'h0003ffff)) - 32'sh00020000;
      3: return $urandom_range(0, 1) ? 32'sh7fffffff : -32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_factor();
    case ($urandom_range(0, 5))
      0, 1, 2: return $signed($urandom_range(0, 32'h0001ffff)) - 32'sh00010000 + 32'sh8000;
      3: return $urandom_range(0, 1) ? 32'sh00010000 : -32'sh00010000;
      4: return $urandom_range(0, 1) ? 32'sh7fffffff : -32'sh80000000;
      default: return $urandom;
    endcase
  endfunction

  // mostly legal indices for the current shape, some out of range or any 5-bit value
  function automatic logic [4:0] pick_index(int unsigned lim);
    case ($urandom_range(0, 19))
      0: return 5'd0;
      1: return 5'($urandom_range(0, 31));
      2: return (lim < 31) ? 5'($urandom_range(lim + 1, 31)) : 5'd31;
      default: return 5'($urandom_range(1, lim));
    endcase
  endfunction

  function automatic cmd_t random_cmd();
    cmd_t c;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    c.factor = pick_factor();
    c.elem_value = pick_value();
    if (pick < 35) c.func = FN_WRITE;
    else if (pick < 55) c.func = FN_READ;
    else if (pick < 88) c.func = func_t'($urandom_range(FN_SCALE_ROW, FN_ADD_COL));
    else if (pick < 95) c.func = FN_STATUS;
    else if (pick < 97) c.func = FN_CLEAR;
    else c.func = func_t'($urandom_range(10, 15));
    if (c.func inside {FN_SCALE_COL, FN_SWAP_COL, FN_ADD_COL}) begin
      c.index_a = pick_index(cols_used);
      c.index_b = pick_index(cols_used);
    end else if (c.func inside {FN_WRITE, FN_READ}) begin
      c.index_a = pick_index(rows_used);
      c.index_b = pick_index(cols_used);
    end else begin
      c.index_a = pick_index(rows_used);
      c.index_b = pick_index(rows_used);
    end
    return c;
  endfunction

  task automatic run_random(int unsigned n);
    for (int i = 0; i < n; i++) begin
      if (i % 40 == 0) begin
        fast_sender = $urandom_range(0, 3) == 0;
        fast_receiver = $urandom_range(0, 3) == 0;
      end
      send_cmd(random_cmd());
    end
    fast_sender = 1'b0;
    fast_receiver = 1'b0;
  endtask

  task automatic test_directed_ops();
    send_op(FN_CLEAR, 0, 0);
    send_op(FN_STATUS, 0, 0);
    send_op(FN_WRITE, 1, 1, 0, 32'sh7fffffff);
    send_op(FN_WRITE, 16, 16, 0, -32'sh80000000);
    send_op(FN_WRITE, 1, 16, 0, 32'sh00018000);
    send_op(FN_STATUS, 0, 0);
    send_op(FN_READ, 16, 16);
    send_op(FN_SCALE_ROW, 1, 31, 32'sh7fffffff);
    send_op(FN_SCALE_COL, 16, 0, -32'sh80000000);
    send_op(FN_SCALE_ROW, 1, 0, 32'sh00008000);
    send_op(FN_SWAP_ROW, 1, 16);
    send_op(FN_ADD_ROW, 16, 16, 32'sh00010000);
    send_op(FN_SWAP_COL, 1, 16);
    send_op(FN_ADD_COL, 1, 16, -32'sh00018000);
    send_op(FN_READ, 1, 1);
    send_op(FN_READ, 16, 1);
    send_op(FN_READ, 0, 1);
    send_op(FN_WRITE, 17, 1, 0, 32'sh1234);
    send_op(FN_ADD_ROW, 1, 31);
    send_op(FN_SWAP_COL, 0, 1);
    send_op(FN_STATUS, 0, 0);
    send_op(4'd10, 1, 1);
    send_op(4'd15, 31, 31, -1, -1);
    send_op(FN_CLEAR, 0, 0);
    send_op(FN_STATUS, 0, 0);
  endtask

  task automatic test_triangular_shapes();
    set_shape(4, 4);
    send_op(FN_CLEAR, 0, 0);
    for (int r = 1; r <= 4; r++)
      for (int c = r; c <= 4; c++) send_op(FN_WRITE, r, c, 0, pick_value() | 1);
    send_op(FN_STATUS, 0, 0);
    send_op(FN_SWAP_ROW, 1, 4);
    send_op(FN_STATUS, 0, 0);
    send_op(FN_CLEAR, 0, 0);
    send_op(FN_WRITE, 3, 2, 0, 32'sh10000);
    send_op(FN_STATUS, 0, 0);
    set_shape(4, 5);
    send_op(FN_STATUS, 0, 0);
  endtask

  task automatic test_shapes();
    logic [31:0] shapes [7][2];
    shapes = '{'{16, 16}, '{1, 1}, '{1, 16}, '{16, 1}, '{0, 31},
               '{32'hffff_ffe3, 32'h0000_0105}, '{5, 9}};
    foreach (shapes[i]) begin
      set_shape(shapes[i][0], shapes[i][1]);
      run_random(70);
    end
    set_shape($urandom, $urandom);
    run_random(60);
    set_shape(16, 16);
    run_random(150);
  endtask

  task automatic test_backpressure();
    wait_drained();
    hold_off_cycles = 600;
    fast_sender = 1'b1;
    for (int i = 0; i < 25; i++) send_op(FN_WRITE, $urandom_range(1, rows_used),
                                         $urandom_range(1, cols_used), 0, pick_value());
    fast_sender = 1'b0;
    wait_drained();
    run_random(100);
  endtask

  // receiver: per-beat stall, or one long hold-off when requested
  initial begin
    int unsigned n;
    rsp.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (hold_off_cycles != 0) begin
        n = hold_off_cycles;
        hold_off_cycles = 0;
      end else begin
        n = fast_receiver ? 0 : $urandom_range(0, 19);
      end
      if (n > 0) begin
        rsp.ready <= 1'b0;
        repeat (n) @(negedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
      while (!rsp.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && rsp.valid && rsp.ready) begin
      beats_checked++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat %p", $time, rsp.data);
      end else begin
        want = pending_results.pop_front();
        if (rsp.data.read_value !== want.read_value) begin
          errors++;
          $display("%0t read_value expected %h actual %h", $time, want.read_value,
                   rsp.data.read_value);
        end
        if (rsp.data.ok !== want.ok) begin
          errors++;
          $display("%0t ok expected %b actual %b", $time, want.ok, rsp.data.ok);
        end
        if (rsp.data.all_zero !== want.all_zero) begin
          errors++;
          $display("%0t all_zero expected %b actual %b", $time, want.all_zero,
                   rsp.data.all_zero);
        end
        if (rsp.data.upper_tri !== want.upper_tri) begin
          errors++;
          $display("%0t upper_tri expected %b actual %b", $time, want.upper_tri,
                   rsp.data.upper_tri);
        end
        if (rsp.data.lower_tri !== want.lower_tri) begin
          errors++;
          $display("%0t lower_tri expected %b actual %b", $time, want.lower_tri,
                   rsp.data.lower_tri);
        end
      end
    end
  end

  initial begin
    rst = 1'b1;
    errors = 0;
    beats_sent = 0;
    beats_checked = 0;
    config_writes = 0;
    fast_sender = 1'b0;
    fast_receiver = 1'b0;
    hold_off_cycles = 0;
    cmd.valid = 1'b0;
    cmd.data = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    rows_used = MAX_DIM;
    cols_used = MAX_DIM;
    for (int i = 0; i < DEPTH; i++) matrix[i] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_ops();
    test_triangular_shapes();
    test_shapes();
    test_backpressure();
    wait_drained();
    repeat (600) @(negedge clk);
    $display("sent %0d commands, checked %0d results, %0d register writes, %0d cycles",
             beats_sent, beats_checked, config_writes, cycles);
    $display("covered all ops, bad indices, unused codes, saturation and shape extremes");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_results.size());
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
